@@ design/fsrd_pkg.sv @@
// fsrd_pkg: shared types and constants for the front slot ring deque
// no dependencies; used by the interfaces, the control path and the top level
package fsrd_pkg;

    localparam int RING_DEPTH_DEF = 16;
    localparam int ITEM_WIDTH_DEF = 32;

    localparam int          RING_LEN_W     = 5;
    localparam logic [4:0]  RING_LEN_RESET = 5'd16;

    typedef enum logic [1:0] {
        CMD_POST_BACK  = 2'd0,
        CMD_POST_FRONT = 2'd1,
        CMD_GET        = 2'd2,
        CMD_PEEK       = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_NULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

endpackage

@@ design/fsrd_if.sv @@
// fsrd_cmd_if / fsrd_rsp_if: valid/ready channels for requests and results
// depends on fsrd_pkg for the command and status types
interface fsrd_cmd_if
    import fsrd_pkg::*;
#(
    parameter int ITEM_WIDTH = ITEM_WIDTH_DEF
);
    logic                  valid;
    logic                  ready;
    cmd_t                  command;
    logic [ITEM_WIDTH-1:0] item_value;

    modport source (output valid, output command, output item_value, input ready);
    modport sink   (input valid, input command, input item_value, output ready);
endinterface

interface fsrd_rsp_if
    import fsrd_pkg::*;
#(
    parameter int ITEM_WIDTH = ITEM_WIDTH_DEF,
    parameter int COUNT_W    = 5
);
    logic                  valid;
    logic                  ready;
    status_t               status;
    logic [ITEM_WIDTH-1:0] read_value;
    logic [COUNT_W-1:0]    ring_used;
    logic [COUNT_W-1:0]    peak_used;

    modport source (output valid, output status, output read_value, output ring_used,
                    output peak_used, input ready);
    modport sink   (input valid, input status, input read_value, input ring_used,
                    input peak_used, output ready);
endinterface

@@ design/fsrd_ram.sv @@
// fsrd_ram: generic single write port ram with one registered read port
// no dependencies
module fsrd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

@@ design/fsrd_ctrl.sv @@
// fsrd_ctrl: queue state (front slot, indices, counts, length register) and
// the per-request update; drives the ring ram ports; depends on fsrd_pkg
module fsrd_ctrl
    import fsrd_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF,
    parameter int ITEM_WIDTH = ITEM_WIDTH_DEF,
    localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1,
    localparam int CW = $clog2(RING_DEPTH + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [RING_LEN_W-1:0] cfg_data,
    input  logic                  fire,
    input  cmd_t                  command,
    input  logic [ITEM_WIDTH-1:0] item_value,
    output status_t               res_status,
    output logic [ITEM_WIDTH-1:0] res_read,
    output logic [CW-1:0]         res_used,
    output logic [CW-1:0]         res_peak,
    output logic                  ram_we,
    output logic [IW-1:0]         ram_waddr,
    output logic [ITEM_WIDTH-1:0] ram_wdata,
    output logic [IW-1:0]         ram_raddr,
    input  logic [ITEM_WIDTH-1:0] ram_rdata
);
    logic [RING_LEN_W-1:0] len_reg;
    logic [ITEM_WIDTH-1:0] front_reg, front_next;
    logic [IW-1:0]         head_reg, head_next;
    logic [IW-1:0]         tail_reg, tail_next;
    logic [CW-1:0]         used_reg, used_next;
    logic [CW-1:0]         peak_reg, peak_next;
    logic                  byp_reg;
    logic [ITEM_WIDTH-1:0] byp_data_reg;
    logic [CW-1:0]         eff_len;
    logic [ITEM_WIDTH-1:0] tail_value;
    logic                  wr;

    // wrap to zero at the effective length or at the physical depth
    function automatic logic [IW-1:0] idx_step(logic [IW-1:0] i, logic [CW-1:0] len);
        logic [IW:0] n;
        n = {1'b0, i} + (IW+1)'(1);
        if (32'(n) >= 32'(len) || 32'(n) >= RING_DEPTH)
            return '0;
        else
            return n[IW-1:0];
    endfunction

    assign eff_len = (32'(len_reg) > RING_DEPTH) ? CW'(RING_DEPTH) : CW'(len_reg);

    // ram output plus forwarding of a write that hit the address being read
    assign tail_value = byp_reg ? byp_data_reg : ram_rdata;

    always_comb
    begin
        front_next = front_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        used_next  = used_reg;
        peak_next  = peak_reg;
        res_status = ST_OK;
        res_read   = '0;
        wr         = 1'b0;
        ram_waddr  = head_reg;
        ram_wdata  = item_value;

        case (command)
            CMD_POST_BACK, CMD_POST_FRONT:
            begin
                if (item_value == '0)
                begin
                    res_status = ST_NULL;
                end
                else if (used_reg >= eff_len)
                begin
                    res_status = ST_FULL;
                end
                else if (front_reg == '0)
                begin
                    front_next = item_value;
                end
                else if (command == CMD_POST_BACK)
                begin
                    wr        = 1'b1;
                    ram_waddr = head_reg;
                    ram_wdata = item_value;
                    head_next = idx_step(head_reg, eff_len);
                    used_next = used_reg + CW'(1);
                end
                else
                begin
                    if (tail_reg == '0)
                        tail_next = IW'(eff_len - CW'(1));
                    else
                        tail_next = tail_reg - IW'(1);
                    wr         = 1'b1;
                    ram_waddr  = tail_next;
                    ram_wdata  = front_reg;
                    front_next = item_value;
                    used_next  = used_reg + CW'(1);
                end
            end
            CMD_GET, CMD_PEEK:
            begin
                res_read = front_reg;
                if (front_reg == '0)
                begin
                    res_status = ST_EMPTY;
                end
                else if (command == CMD_GET)
                begin
                    if (used_reg != '0)
                    begin
                        front_next = tail_value;
                        tail_next  = idx_step(tail_reg, eff_len);
                        used_next  = used_reg - CW'(1);
                    end
                    else
                    begin
                        front_next = '0;
                    end
                end
            end
            default:
            begin
                res_status = ST_OK;
            end
        endcase

        if (used_next > peak_reg)
            peak_next = used_next;

        res_used = used_next;
        res_peak = peak_next;
    end

    assign ram_we    = fire && wr;
    // keep the ram pointed at whatever tail will be after this cycle
    assign ram_raddr = fire ? tail_next : tail_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= RING_LEN_RESET;
            front_reg <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            used_reg  <= '0;
            peak_reg  <= '0;
            byp_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                len_reg <= cfg_data;
            if (fire)
            begin
                front_reg <= front_next;
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                used_reg  <= used_next;
                peak_reg  <= peak_next;
            end
            byp_reg <= ram_we && (ram_waddr == ram_raddr);
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= ram_wdata;
    end
endmodule

@@ design/front_slot_ring_deque.sv @@
// front_slot_ring_deque: top level of the pointer deque with a front slot
// depends on fsrd_pkg, fsrd_if, fsrd_ram and fsrd_ctrl
//
// usage
// - cmd channel: one request per handshake (valid && ready), carrying a
//   command (post at back, post at front, get, peek) and an item value
// - rsp channel: exactly one result per request, in request order, with
//   status, the front item for get/peek, ring use and the high-water mark
// - cfg_we/cfg_data: writes ring_length; only while no request is in flight
// - latency: a result is presented the cycle after its request is taken
// - throughput: one request per cycle while rsp.ready is high; the front slot
//   update and the ring read for the refill on get both resolve in that single
//   cycle, since the ram keeps its registered read pointed at the current tail
// - a write into the ram at the address being read is forwarded, so a get
//   right after a post at front sees the saved front item
// - stall: while a result waits and rsp.ready is low, cmd.ready drops; the
//   result register drains and refills in the same cycle when rsp.ready is high
// - reset: front empty, indices and counts zero, ring_length 16; the ring
//   contents are not cleared; a length change can expose unwritten entries
module front_slot_ring_deque
    import fsrd_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF,
    parameter int ITEM_WIDTH = ITEM_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    fsrd_cmd_if.sink              cmd,
    fsrd_rsp_if.source            rsp,
    input  logic                  cfg_we,
    input  logic [RING_LEN_W-1:0] cfg_data
);
    localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW = $clog2(RING_DEPTH + 1);

    // request taken this cycle
    logic                  fire;

    // combinational result of the current request
    status_t               res_status;
    logic [ITEM_WIDTH-1:0] res_read;
    logic [CW-1:0]         res_used;
    logic [CW-1:0]         res_peak;

    // ring ram ports
    logic                  ram_we;
    logic [IW-1:0]         ram_waddr;
    logic [ITEM_WIDTH-1:0] ram_wdata;
    logic [IW-1:0]         ram_raddr;
    logic [ITEM_WIDTH-1:0] ram_rdata;

    // result register
    logic                  rsp_valid_reg;
    status_t               rsp_status_reg;
    logic [ITEM_WIDTH-1:0] rsp_read_reg;
    logic [CW-1:0]         rsp_used_reg;
    logic [CW-1:0]         rsp_peak_reg;

    // take a request whenever the result register is empty or being drained
    assign cmd.ready = !rsp_valid_reg || rsp.ready;
    assign fire      = cmd.valid && cmd.ready;

    fsrd_ctrl #(
        .RING_DEPTH (RING_DEPTH),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .fire       (fire),
        .command    (cmd.command),
        .item_value (cmd.item_value),
        .res_status (res_status),
        .res_read   (res_read),
        .res_used   (res_used),
        .res_peak   (res_peak),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

    // ring storage behind the front slot
    fsrd_ram #(
        .WIDTH (ITEM_WIDTH),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // payload only loads with a new request
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rsp_status_reg <= res_status;
            rsp_read_reg   <= res_read;
            rsp_used_reg   <= res_used;
            rsp_peak_reg   <= res_peak;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = rsp_status_reg;
    assign rsp.read_value = rsp_read_reg;
    assign rsp.ring_used  = rsp_used_reg;
    assign rsp.peak_used  = rsp_peak_reg;

    // high-water mark never below the current ring use
    a_peak_ge_used: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_peak_reg >= rsp_used_reg))
        else $error("peak_used below ring_used");

    // every taken request yields a result in the next cycle
    a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> rsp_valid_reg)
        else $error("request taken without a result");

    // an empty report never carries an item
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_status_reg == ST_EMPTY) |-> (rsp_read_reg == '0))
        else $error("empty status with nonzero read value");

    // ring use moves by at most one per request
    a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
        fire ##1 fire |=> (rsp_used_reg == $past(rsp_used_reg)
                           || rsp_used_reg == $past(rsp_used_reg) + CW'(1)
                           || rsp_used_reg == $past(rsp_used_reg) - CW'(1)))
        else $error("ring use jumped by more than one");
endmodule

@@ sim/fsrd_result_checker.sv @@
`timescale 1ns / 100ps
// fsrd_result_checker: shadows the deque and compares every result it returns
// depends on fsrd_pkg and the fsrd_cmd_if / fsrd_rsp_if interfaces
module fsrd_result_checker
    import fsrd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    fsrd_cmd_if                   cmd,
    fsrd_rsp_if                   rsp,
    input  logic                  cfg_we,
    input  logic [RING_LEN_W-1:0] cfg_data,
    output int                    pending_results,
    output int                    mismatch_count,
    output int                    full_refusals,
    output int                    empty_reads,
    output int                    deepest_use
);

    localparam int DEPTH = RING_DEPTH_DEF;

    typedef struct packed {
        status_t                   status;
        logic [ITEM_WIDTH_DEF-1:0] read_value;
        logic [4:0]                ring_used;
        logic [4:0]                peak_used;
    } deque_result_t;

    logic [ITEM_WIDTH_DEF-1:0] front_slot;
    logic [ITEM_WIDTH_DEF-1:0] ring_mem [DEPTH];
    logic [3:0]                head_ptr;
    logic [3:0]                tail_ptr;
    logic [4:0]                ring_count;
    logic [4:0]                peak_cnt;
    logic [RING_LEN_W-1:0]     length_reg;
    deque_result_t             expected_results [$];
    int                        errors;
    int                        fulls;
    int                        empties;

    // index step with wrap at the active length or the physical depth
    function automatic logic [3:0] ring_advance(logic [3:0] idx, logic [4:0] len);
        int n;
        n = int'(idx) + 1;
        if (n >= int'(len) || n >= DEPTH)
            n = 0;
        return n[3:0];
    endfunction

    // applies one request to the shadow state and returns its result
    function automatic deque_result_t apply_request(cmd_t op, logic [ITEM_WIDTH_DEF-1:0] value);
        logic [4:0]    len;
        logic          grew;
        deque_result_t r;
        len          = (length_reg > 5'(DEPTH)) ? 5'(DEPTH) : length_reg;
        grew         = 1'b0;
        r.status     = ST_OK;
        r.read_value = '0;
        if (op == CMD_POST_BACK || op == CMD_POST_FRONT)
        begin
            if (value == '0)
                r.status = ST_NULL;
            else if (ring_count >= len)
                r.status = ST_FULL;
            else if (front_slot == '0)
                front_slot = value;
            else if (op == CMD_POST_BACK)
            begin
                ring_mem[head_ptr] = value;
                head_ptr           = ring_advance(head_ptr, len);
                grew               = 1'b1;
            end
            else
            begin
                tail_ptr           = (tail_ptr == 4'd0) ? 4'(len - 5'd1) : tail_ptr - 4'd1;
                ring_mem[tail_ptr] = front_slot;
                front_slot         = value;
                grew               = 1'b1;
            end
        end
        else
        begin
            r.read_value = front_slot;
            if (front_slot == '0)
                r.status = ST_EMPTY;
            else if (op == CMD_GET)
            begin
                if (ring_count != 5'd0)
                begin
                    front_slot = ring_mem[tail_ptr];
                    tail_ptr   = ring_advance(tail_ptr, len);
                    ring_count = ring_count - 5'd1;
                end
                else
                    front_slot = '0;
            end
        end
        if (grew)
        begin
            ring_count = ring_count + 5'd1;
            if (ring_count > peak_cnt)
                peak_cnt = ring_count;
        end
        r.ring_used = ring_count;
        r.peak_used = peak_cnt;
        return r;
    endfunction

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        deque_result_t want;
        deque_result_t fresh;
        if (!rst_n)
        begin
            front_slot = '0;
            head_ptr   = '0;
            tail_ptr   = '0;
            ring_count = '0;
            peak_cnt   = '0;
            length_reg = RING_LEN_RESET;
            errors     = 0;
            fulls      = 0;
            empties    = 0;
            expected_results.delete();
            pending_results <= 0;
            mismatch_count  <= 0;
            full_refusals   <= 0;
            empty_reads     <= 0;
            deepest_use     <= 0;
        end
        else
        begin
            if (cfg_we)
                length_reg = cfg_data;
            if (cmd.valid && cmd.ready)
            begin
                fresh = apply_request(cmd.command, cmd.item_value);
                if (fresh.status == ST_FULL)
                    fulls++;
                if (fresh.status == ST_EMPTY)
                    empties++;
                expected_results.push_back(fresh);
            end
            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with none expected, status %0d value 0x%0h",
                             $time, rsp.status, rsp.read_value);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("status", 32'(want.status), 32'(rsp.status));
                    compare_field("read_value", want.read_value, rsp.read_value);
                    compare_field("ring_used", 32'(want.ring_used), 32'(rsp.ring_used));
                    compare_field("peak_used", 32'(want.peak_used), 32'(rsp.peak_used));
                end
            end
            pending_results <= expected_results.size();
            mismatch_count  <= errors;
            full_refusals   <= fulls;
            empty_reads     <= empties;
            deepest_use     <= int'(peak_cnt);
        end
    end

endmodule

@@ sim/tb_front_slot_ring_deque.sv @@
`timescale 1ns / 100ps
// tb_front_slot_ring_deque: request stimulus, result back-pressure and verdict
// depends on fsrd_pkg, fsrd_if, front_slot_ring_deque and fsrd_result_checker
module tb_front_slot_ring_deque;
    import fsrd_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int PHASE_ITEMS = 114;
    localparam int NUM_PHASES  = 14;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [RING_LEN_W-1:0] cfg_data;

    fsrd_cmd_if cmd_if ();
    fsrd_rsp_if rsp_if ();

    // filled in by the checker
    int pending_results;
    int mismatch_count;
    int full_refusals;
    int empty_reads;
    int deepest_use;

    // stimulus bookkeeping
    bit steady      = 1'b1;
    bit valid_on    = 1'b0;
    int idle_cycles = 0;
    int cfg_writes  = 0;
    int cmd_tally [4];

    front_slot_ring_deque dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd_if),
        .rsp      (rsp_if),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    fsrd_result_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd_if),
        .rsp             (rsp_if),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .pending_results (pending_results),
        .mismatch_count  (mismatch_count),
        .full_refusals   (full_refusals),
        .empty_reads     (empty_reads),
        .deepest_use     (deepest_use)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // gap length: mostly from the lowest of three ranges, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 2);
        if (r < 95)
            return $urandom_range(3, 6);
        return $urandom_range(12, 40);
    endfunction

    // item values: mostly random, with null and the extremes mixed in
    function automatic logic [31:0] pick_item();
        int r;
        r = $urandom_range(0, 39);
        if (r == 0)
            return 32'h0;
        if (r == 1)
            return 32'hFFFF_FFFF;
        if (r == 2)
            return 32'h1;
        if (r == 3)
            return 32'h8000_0000;
        return $urandom;
    endfunction

    function automatic logic [31:0] nonzero_item();
        logic [31:0] v;
        v = $urandom;
        while (v == 32'h0)
            v = $urandom;
        return v;
    endfunction

    // result side back-pressure; no new stall starts during steady stretches
    initial
    begin
        int hold;
        hold = 0;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                rsp_if.ready <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 5) == 0)
            begin
                hold = pick_gap() - 1;
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= 1'b1;
        end
    end

    // cycles without any handshake on either channel
    always @(posedge clk)
    begin
        if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // watchdog: a hung handshake ends the run
    initial
    begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // one request, held until taken; valid only drops when a gap follows
    task automatic send_request(cmd_t op, logic [31:0] value);
        int gap;
        cmd_if.valid      <= 1'b1;
        cmd_if.command    <= op;
        cmd_if.item_value <= value;
        valid_on = 1'b1;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        cmd_tally[int'(op)]++;
        if (steady || $urandom_range(0, 99) < 65)
            gap = 0;
        else
            gap = pick_gap();
        if (gap > 0)
        begin
            cmd_if.valid <= 1'b0;
            valid_on = 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop sending and let every outstanding result come back
    task automatic drain_results();
        if (valid_on)
        begin
            cmd_if.valid <= 1'b0;
            valid_on = 1'b0;
        end
        // the checker's count is a registered copy of its queue size
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        // settling margin after the last result
        repeat (2) @(posedge clk);
    endtask

    task automatic write_length(logic [RING_LEN_W-1:0] len);
        cfg_we   <= 1'b1;
        cfg_data <= len;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cfg_writes++;
    endtask

    // random traffic that swings between filling and draining so that
    // both the full and the empty ends of the ring get hit
    task automatic run_phase(int count);
        bit          filling;
        int          r;
        cmd_t        op;
        logic [31:0] value;
        filling = 1'b1;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                filling = !filling;
            r = $urandom_range(0, 99);
            if (r < (filling ? 80 : 20))
            begin
                op    = $urandom_range(0, 1) ? CMD_POST_BACK : CMD_POST_FRONT;
                value = pick_item();
            end
            else
            begin
                op    = ($urandom_range(0, 3) == 0) ? CMD_PEEK : CMD_GET;
                value = $urandom;
            end
            send_request(op, value);
            // sender holds off mid-phase until the queue of results is empty
            if (i == count / 2)
                drain_results();
        end
    endtask

    initial
    begin
        logic [RING_LEN_W-1:0] sweep [NUM_PHASES] =
            '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd16, 5'd2,
              5'd9, 5'd17, 5'd7, 5'd3, 5'd16, 5'd12, 5'd5};

        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_data          <= '0;
        cmd_if.valid      <= 1'b0;
        cmd_if.command    <= CMD_PEEK;
        cmd_if.item_value <= '0;
        foreach (cmd_tally[k])
            cmd_tally[k] = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty reads, null posts, extreme values, both post ends
        send_request(CMD_GET, 32'h0);
        send_request(CMD_PEEK, 32'h0);
        send_request(CMD_POST_BACK, 32'h0);
        send_request(CMD_POST_FRONT, 32'h0);
        send_request(CMD_POST_BACK, 32'hFFFF_FFFF);
        send_request(CMD_PEEK, 32'h0);
        send_request(CMD_POST_FRONT, 32'h1);
        send_request(CMD_POST_BACK, 32'h8000_0000);
        send_request(CMD_POST_BACK, 32'h5A5A_A5A5);
        send_request(CMD_PEEK, 32'hFFFF_FFFF);
        repeat (4) send_request(CMD_GET, 32'h0);
        send_request(CMD_GET, 32'h0);
        drain_results();

        // fill to full at the reset length so every ring entry gets written
        // before any length change; then refusals at full, null before full
        steady = 1'b0;
        repeat (17)
            send_request($urandom_range(0, 1) ? CMD_POST_BACK : CMD_POST_FRONT, nonzero_item());
        send_request(CMD_POST_BACK, nonzero_item());
        send_request(CMD_POST_FRONT, nonzero_item());
        send_request(CMD_POST_BACK, 32'h0);
        repeat (17)
            send_request($urandom_range(0, 3) == 0 ? CMD_PEEK : CMD_GET, $urandom);
        repeat (17)
            send_request(CMD_GET, $urandom);
        send_request(CMD_GET, 32'h0);

        // random phases over a sweep of lengths, including zero and clamped
        // values; the queue keeps its contents across each length change
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_results();
            write_length(sweep[p]);
            steady = (p % 4 == 3);
            run_phase(PHASE_ITEMS);
        end

        drain_results();
        repeat (4) @(posedge clk);

        $display("sent %0d post-back, %0d post-front, %0d get, %0d peek over %0d length writes",
                 cmd_tally[0], cmd_tally[1], cmd_tally[2], cmd_tally[3], cfg_writes);
        $display("saw %0d full refusals and %0d empty reads; ring use peaked at %0d",
                 full_refusals, empty_reads, deepest_use);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
design/fsrd_pkg.sv
design/fsrd_if.sv
design/fsrd_ram.sv
design/fsrd_ctrl.sv
design/front_slot_ring_deque.sv
sim/fsrd_result_checker.sv
sim/tb_front_slot_ring_deque.sv
